// File: sv/mbpdu_pkg.sv
// ----------------------------------------------------------------------------
// mbpdu_pkg
// Shared types and codes for the Modbus PDU parser: request and result
// layouts, frame format classes, status codes and the format classifier.
// ----------------------------------------------------------------------------
package mbpdu_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_last;
    } t_rx_req;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic [7:0]  byte_count;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        is_exception;
        logic [1:0]  status;
        logic        last_result;
    } t_pdu_result;

    typedef logic [2:0] t_fmt;

    localparam t_fmt FMT_UNKNOWN    = 3'd0;
    localparam t_fmt FMT_REQ_READ   = 3'd1;
    localparam t_fmt FMT_REQ_SINGLE = 3'd2;
    localparam t_fmt FMT_REQ_MULTI  = 3'd3;
    localparam t_fmt FMT_RSP_READ   = 3'd4;
    localparam t_fmt FMT_RSP_EXC    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_OVERRUN  = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic MODE_REQUEST  = 1'b0;
    localparam logic MODE_RESPONSE = 1'b1;

    localparam logic [7:0] FC_EXC_BIT      = 8'h80;
    localparam logic [7:0] FC_READ_COILS   = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS  = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FC_READ_INPUT   = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
    localparam logic [7:0] FC_WRITE_REG    = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS   = 8'd16;

    localparam logic [9:0] LEN_MIN_ANY   = 10'd2;
    localparam logic [9:0] LEN_MIN_BASIC = 10'd5;
    localparam logic [9:0] LEN_MIN_MULTI = 10'd6;
    localparam logic [9:0] RSP_DATA_OFS  = 10'd4;
    localparam logic [9:0] MULTI_DATA_OFS = 10'd6;

    function automatic t_fmt classify(input logic [7:0] fc, input logic mode);
        t_fmt f;
        f = FMT_UNKNOWN;
        if (mode == MODE_RESPONSE) begin
            if ((fc & FC_EXC_BIT) != 8'd0) begin
                f = FMT_RSP_EXC;
            end else if (fc >= FC_READ_COILS && fc <= FC_READ_INPUT) begin
                f = FMT_RSP_READ;
            end
        end else begin
            if (fc >= FC_READ_COILS && fc <= FC_READ_INPUT) begin
                f = FMT_REQ_READ;
            end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG) begin
                f = FMT_REQ_SINGLE;
            end else if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
                f = FMT_REQ_MULTI;
            end
        end
        return f;
    endfunction

endpackage

// File: sv/modbus_pdu_parser.sv
// ----------------------------------------------------------------------------
// modbus_pdu_parser
// Byte-serial Modbus PDU parser with payload and frame summary results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid/o_in_ready/i_in_data carries one frame byte per
//   request, function code first, frame_last set on the final byte.
//   Output channel o_out_valid/i_out_ready/o_out_data carries payload items
//   (with their index) and, on the final byte, a frame summary item with the
//   captured fields and a status. Discard payload when status is not ok.
//   i_cfg_we/i_cfg_data write parse_mode (0 requests, 1 responses); write it
//   only while the block is idle.
//   A result is registered and visible in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while o_in_ready is high; each result is
//   one output transfer, so a final byte with payload plus summary adds two results.
//   Results sit in a four-entry output queue; o_in_ready is high while at
//   least two entries are free, so a stalled receiver holds off the input
//   without losing results.
//   Reset (synchronous, active low) clears the parse state, the mode and the
//   queue; the block accepts bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module modbus_pdu_parser
    import mbpdu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_rx_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pdu_result o_out_data
);

    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);

    logic              r_parse_mode;
    logic [8:0]        r_pos;
    logic [7:0]        r_func;
    logic [15:0]       r_addr;
    logic [15:0]       r_qty;
    logic [7:0]        r_cnt;

    t_pdu_result       r_queue [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr;
    logic [QPtrW-1:0]  r_rd_ptr;
    logic [QPtrW:0]    r_level;

    logic              in_fire;
    logic              out_fire;
    logic              pos0;
    logic [7:0]        b;
    logic              last;
    logic [7:0]        fc;
    t_fmt              fmt;
    logic [15:0]       n_addr;
    logic [15:0]       n_qty;
    logic [7:0]        n_cnt;
    logic [8:0]        n_pos;
    logic              has_pl;
    logic [8:0]        pl_idx;
    logic              exc;
    logic [9:0]        len;
    logic [1:0]        status;
    t_pdu_result       pl_res;
    t_pdu_result       sum_res;
    t_pdu_result       first_res;
    logic [1:0]        push_n;

    assign o_in_ready  = (r_level <= (QPtrW+1)'(QDepth - 2));
    assign in_fire     = i_in_valid & o_in_ready;
    assign o_out_valid = (r_level != '0);
    assign out_fire    = o_out_valid & i_out_ready;
    assign o_out_data  = r_queue[r_rd_ptr];

    assign b    = i_in_data.rx_byte;
    assign last = i_in_data.frame_last;
    assign pos0 = (r_pos == 9'd0);
    assign fc   = pos0 ? b : r_func;
    assign fmt  = classify(fc, r_parse_mode);
    assign exc  = (fmt == FMT_RSP_EXC);
    assign len  = {1'b0, r_pos} + 10'd1;

    // field capture per byte position
    always_comb begin
        n_addr = r_addr;
        n_qty  = r_qty;
        n_cnt  = r_cnt;
        has_pl = 1'b0;
        pl_idx = '0;
        if (pos0) begin
            n_addr = '0;
            n_qty  = '0;
            n_cnt  = '0;
            if (fmt == FMT_REQ_SINGLE) begin
                n_qty = 16'd1;
                n_cnt = 8'd2;
            end
            if (fmt == FMT_RSP_EXC) begin
                n_cnt = 8'd1;
            end
        end else begin
            if (fmt != FMT_UNKNOWN && fmt != FMT_RSP_EXC) begin
                if (r_pos == 9'd1) begin
                    n_addr = {b, r_addr[7:0]};
                end else if (r_pos == 9'd2) begin
                    n_addr = {r_addr[15:8], b};
                end
            end
            case (fmt)
                FMT_REQ_READ, FMT_REQ_MULTI: begin
                    if (r_pos == 9'd3) begin
                        n_qty = {b, r_qty[7:0]};
                    end else if (r_pos == 9'd4) begin
                        n_qty = {r_qty[15:8], b};
                    end else if (fmt == FMT_REQ_MULTI) begin
                        if (r_pos == 9'd5) begin
                            n_cnt = b;
                        end else if (r_pos >= 9'd6 &&
                                     (r_pos - 9'd6) < {1'b0, r_cnt}) begin
                            has_pl = 1'b1;
                            pl_idx = r_pos - 9'd6;
                        end
                    end
                end
                FMT_REQ_SINGLE: begin
                    if (r_pos == 9'd3 || r_pos == 9'd4) begin
                        has_pl = 1'b1;
                        pl_idx = r_pos - 9'd3;
                    end
                end
                FMT_RSP_READ: begin
                    if (r_pos == 9'd3) begin
                        n_cnt = b;
                        n_qty = (r_func >= FC_READ_HOLDING) ? {9'd0, b[7:1]}
                                                            : {5'd0, b, 3'd0};
                    end else if (r_pos >= 9'd4 &&
                                 (r_pos - 9'd4) < {1'b0, r_cnt}) begin
                        has_pl = 1'b1;
                        pl_idx = r_pos - 9'd4;
                    end
                end
                FMT_RSP_EXC: begin
                    if (r_pos == 9'd1) begin
                        has_pl = 1'b1;
                        pl_idx = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // frame status
    always_comb begin
        status = ST_OK;
        if (len < LEN_MIN_ANY) begin
            status = ST_SHORT;
        end else if (fmt == FMT_UNKNOWN) begin
            status = ST_UNKNOWN;
        end else if (fmt == FMT_REQ_MULTI) begin
            if (len < LEN_MIN_MULTI) begin
                status = ST_SHORT;
            end else if (len < MULTI_DATA_OFS + {2'd0, n_cnt}) begin
                status = ST_OVERRUN;
            end
        end else if (fmt == FMT_RSP_READ) begin
            if (len < LEN_MIN_BASIC) begin
                status = ST_SHORT;
            end else if (len < RSP_DATA_OFS + {2'd0, n_cnt}) begin
                status = ST_OVERRUN;
            end
        end else if (fmt != FMT_RSP_EXC) begin
            if (len < LEN_MIN_BASIC) begin
                status = ST_SHORT;
            end
        end
    end

    always_comb begin
        pl_res.result_kind   = KIND_PAYLOAD;
        pl_res.function_code = fc;
        pl_res.start_address = n_addr;
        pl_res.quantity      = n_qty;
        pl_res.byte_count    = n_cnt;
        pl_res.payload_byte  = b;
        pl_res.payload_index = pl_idx[7:0];
        pl_res.is_exception  = exc;
        pl_res.status        = ST_OK;
        pl_res.last_result   = ~last;

        sum_res               = pl_res;
        sum_res.result_kind   = KIND_SUMMARY;
        sum_res.payload_byte  = '0;
        sum_res.payload_index = '0;
        sum_res.status        = status;
        sum_res.last_result   = 1'b1;

        first_res = has_pl ? pl_res : sum_res;
        push_n    = {1'b0, has_pl} + {1'b0, last};
    end

    assign n_pos = last ? 9'd0 : ((r_pos == 9'h1FF) ? r_pos : r_pos + 9'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_mode <= MODE_REQUEST;
            r_pos        <= '0;
            r_func       <= '0;
            r_addr       <= '0;
            r_qty        <= '0;
            r_cnt        <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_level      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_parse_mode <= i_cfg_data;
            end
            if (in_fire) begin
                r_pos    <= n_pos;
                r_func   <= fc;
                r_addr   <= n_addr;
                r_qty    <= n_qty;
                r_cnt    <= n_cnt;
                r_wr_ptr <= r_wr_ptr + QPtrW'(push_n);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            r_level <= r_level + (in_fire ? (QPtrW+1)'(push_n) : '0)
                               - (QPtrW+1)'(out_fire);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_fire && push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= first_res;
        end
        if (in_fire && push_n == 2'd2) begin
            r_queue[r_wr_ptr + QPtrW'(1)] <= sum_res;
        end
    end

endmodule

// File: tb/modbus_pdu_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_pdu_parser_tb
// Drives byte-serial Modbus frames into the parser in request and response
// mode, predicts the payload and summary results in a behavioral model of
// the parse state, and checks every result field by field under mixed
// sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module modbus_pdu_parser_tb
    import mbpdu_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 140;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_rx_req     in_req    = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_pdu_result out_res;

    t_rx_req     rx_bytes_q[$];
    t_pdu_result pdu_results_q[$];

    // parser state as seen by the testbench
    logic        parse_mode = MODE_REQUEST;
    logic [8:0]  pos_r      = '0;
    logic [7:0]  fc_r       = '0;
    logic [15:0] addr_r     = '0;
    logic [15:0] qty_r      = '0;
    logic [7:0]  cnt_r      = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int err_cnt        = 0;
    int n_queued       = 0;
    int n_bytes        = 0;
    int n_results      = 0;
    int status_cnt[4]  = '{0, 0, 0, 0};

    modbus_pdu_parser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_res)
    );

    always #5 clk = ~clk;

    function automatic t_fmt fmt_of(input logic [7:0] fc, input logic m);
        if (m == MODE_RESPONSE) begin
            if (fc[7]) return FMT_RSP_EXC;
            case (fc)
                FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT: return FMT_RSP_READ;
                default: return FMT_UNKNOWN;
            endcase
        end
        case (fc)
            FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT: return FMT_REQ_READ;
            FC_WRITE_COIL, FC_WRITE_REG:   return FMT_REQ_SINGLE;
            FC_WRITE_COILS, FC_WRITE_REGS: return FMT_REQ_MULTI;
            default: return FMT_UNKNOWN;
        endcase
    endfunction

    task automatic parse_byte(input t_rx_req rq);
        t_fmt        f;
        logic [7:0]  b;
        logic        has_pl;
        logic [7:0]  idx;
        logic [9:0]  len;
        logic [1:0]  st;
        t_pdu_result r;
        b      = rq.rx_byte;
        has_pl = 1'b0;
        idx    = '0;
        if (pos_r == 9'd0) begin
            fc_r   = b;
            addr_r = '0;
            qty_r  = '0;
            cnt_r  = '0;
            f      = fmt_of(b, parse_mode);
            if (f == FMT_REQ_SINGLE) begin
                qty_r = 16'd1;
                cnt_r = 8'd2;
            end
            if (f == FMT_RSP_EXC) cnt_r = 8'd1;
        end else begin
            f = fmt_of(fc_r, parse_mode);
            if (f != FMT_UNKNOWN && f != FMT_RSP_EXC) begin
                if (pos_r == 9'd1) addr_r[15:8] = b;
                else if (pos_r == 9'd2) addr_r[7:0] = b;
            end
            case (f)
                FMT_REQ_READ, FMT_REQ_MULTI: begin
                    if (pos_r == 9'd3) qty_r[15:8] = b;
                    else if (pos_r == 9'd4) qty_r[7:0] = b;
                    else if (f == FMT_REQ_MULTI) begin
                        if (pos_r == 9'd5) cnt_r = b;
                        else if (pos_r >= 9'd6 && (pos_r - 9'd6) < {1'b0, cnt_r}) begin
                            has_pl = 1'b1;
                            idx    = 8'(pos_r - 9'd6);
                        end
                    end
                end
                FMT_REQ_SINGLE: begin
                    if (pos_r == 9'd3 || pos_r == 9'd4) begin
                        has_pl = 1'b1;
                        idx    = 8'(pos_r - 9'd3);
                    end
                end
                FMT_RSP_READ: begin
                    if (pos_r == 9'd3) begin
                        cnt_r = b;
                        qty_r = (fc_r >= FC_READ_HOLDING) ? {9'd0, b[7:1]} : {5'd0, b, 3'd0};
                    end else if (pos_r >= 9'd4 && (pos_r - 9'd4) < {1'b0, cnt_r}) begin
                        has_pl = 1'b1;
                        idx    = 8'(pos_r - 9'd4);
                    end
                end
                FMT_RSP_EXC: begin
                    if (pos_r == 9'd1) has_pl = 1'b1;
                end
                default: ;
            endcase
        end

        r.function_code = fc_r;
        r.start_address = addr_r;
        r.quantity      = qty_r;
        r.byte_count    = cnt_r;
        r.is_exception  = (f == FMT_RSP_EXC);
        if (has_pl) begin
            r.result_kind   = KIND_PAYLOAD;
            r.payload_byte  = b;
            r.payload_index = idx;
            r.status        = ST_OK;
            r.last_result   = ~rq.frame_last;
            pdu_results_q   = {pdu_results_q, r};
        end

        if (rq.frame_last) begin
            len = {1'b0, pos_r} + 10'd1;
            st  = ST_OK;
            if (len < LEN_MIN_ANY) st = ST_SHORT;
            else if (f == FMT_UNKNOWN) st = ST_UNKNOWN;
            else if (f == FMT_REQ_MULTI) begin
                if (len < LEN_MIN_MULTI) st = ST_SHORT;
                else if (len < MULTI_DATA_OFS + {2'b0, cnt_r}) st = ST_OVERRUN;
            end else if (f == FMT_RSP_READ) begin
                if (len < LEN_MIN_BASIC) st = ST_SHORT;
                else if (len < RSP_DATA_OFS + {2'b0, cnt_r}) st = ST_OVERRUN;
            end else if (f != FMT_RSP_EXC) begin
                if (len < LEN_MIN_BASIC) st = ST_SHORT;
            end
            r.result_kind   = KIND_SUMMARY;
            r.payload_byte  = '0;
            r.payload_index = '0;
            r.status        = st;
            r.last_result   = 1'b1;
            pdu_results_q   = {pdu_results_q, r};
            pos_r = '0;
        end else if (pos_r != 9'd511) begin
            pos_r = pos_r + 9'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            err_cnt++;
        end
    endtask

    task automatic push_frame(input logic [7:0] frm[$], input bit close);
        t_rx_req r;
        foreach (frm[i]) begin
            r.rx_byte    = frm[i];
            r.frame_last = close && (i == frm.size() - 1);
            rx_bytes_q   = {rx_bytes_q, r};
            n_queued++;
        end
    endtask

    task automatic gen_frame(input logic m);
        logic [7:0] frm[$];
        logic [7:0] fc;
        int         cnt;
        int         len;
        cnt = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(8);
        if ($urandom_range(99) < 12) begin
            len = $urandom_range(1, 8);
            repeat (len) frm = {frm, 8'($urandom_range(255))};
        end else begin
            if (m == MODE_RESPONSE) begin
                if ($urandom_range(3) == 0) begin
                    frm = {frm, 8'($urandom_range(255)) | FC_EXC_BIT};
                    frm = {frm, 8'($urandom_range(255))};
                end else begin
                    fc = FC_READ_COILS + 8'($urandom_range(3));
                    frm = {frm, fc};
                    repeat (2) frm = {frm, 8'($urandom_range(255))};
                    frm = {frm, 8'(cnt)};
                    repeat (cnt) frm = {frm, 8'($urandom_range(255))};
                end
            end else begin
                case ($urandom_range(2))
                    0: fc = FC_READ_COILS + 8'($urandom_range(3));
                    1: fc = $urandom_range(1) ? FC_WRITE_COIL : FC_WRITE_REG;
                    default: fc = $urandom_range(1) ? FC_WRITE_COILS : FC_WRITE_REGS;
                endcase
                frm = {frm, fc};
                repeat (4) frm = {frm, 8'($urandom_range(255))};
                if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
                    frm = {frm, 8'(cnt)};
                    repeat (cnt) frm = {frm, 8'($urandom_range(255))};
                end
            end
            // broken or padded frames
            if ($urandom_range(99) < 15) begin
                len = $urandom_range(1, frm.size());
                while (frm.size() > len) void'(frm.pop_back());
            end else if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(1, 3)) frm = {frm, 8'($urandom_range(255))};
            end
        end
        push_frame(frm, 1'b1);
    endtask

    task automatic drain();
        while (rx_bytes_q.size() != 0 || in_valid || pdu_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        drain();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        parse_mode = m;
    endtask

    always @(posedge clk) begin : drv
        logic    nv;
        t_rx_req nd;
        nv = in_valid;
        nd = in_req;
        if (!rst_n) begin
            nv = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                parse_byte(in_req);
                n_bytes++;
                nv = 1'b0;
            end
            if (!nv && rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nd = rx_bytes_q.pop_front();
                nv = 1'b1;
            end
        end
        in_valid <= nv;
        in_req   <= nd;
    end

    always @(posedge clk) begin : mon
        t_pdu_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (pdu_results_q.size() == 0) begin
                    $error("result with none expected: %h", out_res);
                    err_cnt++;
                end else begin
                    want = pdu_results_q.pop_front();
                    check_field("result_kind", 16'(want.result_kind), 16'(out_res.result_kind));
                    check_field("function_code", 16'(want.function_code),
                                16'(out_res.function_code));
                    check_field("start_address", want.start_address, out_res.start_address);
                    check_field("quantity", want.quantity, out_res.quantity);
                    check_field("byte_count", 16'(want.byte_count), 16'(out_res.byte_count));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(out_res.payload_byte));
                    check_field("payload_index", 16'(want.payload_index),
                                16'(out_res.payload_index));
                    check_field("is_exception", 16'(want.is_exception),
                                16'(out_res.is_exception));
                    check_field("status", 16'(want.status), 16'(out_res.status));
                    check_field("last_result", 16'(want.last_result), 16'(out_res.last_result));
                    if (want.result_kind == KIND_SUMMARY) status_cnt[want.status]++;
                end
            end
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stim
        logic [7:0] frm[$];
        int         base;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(MODE_REQUEST);
        frm = '{8'h03};
        push_frame(frm, 1'b1);
        frm = '{8'hFF, 8'h00};
        push_frame(frm, 1'b1);
        frm = '{8'h06, 8'h12, 8'h34, 8'hAB, 8'hCD};
        push_frame(frm, 1'b1);
        frm = '{8'h10, 8'h00, 8'h01, 8'h00, 8'h02, 8'h03, 8'hAA, 8'hBB};
        push_frame(frm, 1'b1);
        // mode switch in the middle of a frame
        frm = '{8'h03, 8'h00, 8'h01};
        push_frame(frm, 1'b0);
        set_mode(MODE_RESPONSE);
        frm = '{8'h04, 8'hFF};
        push_frame(frm, 1'b1);
        frm = '{8'h83, 8'hFF};
        push_frame(frm, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            set_mode(ph[0] ? MODE_RESPONSE : MODE_REQUEST);
            case (ph / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (ph == 3) begin
                // runs past the position limit
                frm = '{FC_READ_HOLDING, 8'h12, 8'h34, 8'hFF};
                while (frm.size() < 520) frm = {frm, 8'($urandom_range(255))};
                push_frame(frm, 1'b1);
            end
            base = n_queued;
            while (n_queued - base < PHASE_BYTES) gen_frame(parse_mode);
            if (ph == 0) hold_req = 1'b1;
        end

        drain();
        $display("covered %0d frame bytes and %0d results in both parse modes,",
                 n_bytes, n_results);
        $display("summaries ok %0d short %0d unknown %0d overrun %0d, with gaps and a long stall",
                 status_cnt[ST_OK], status_cnt[ST_SHORT], status_cnt[ST_UNKNOWN],
                 status_cnt[ST_OVERRUN]);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
